FILE: hdl/fqp_pkg.sv
`timescale 1ns / 1ps

package fqp_pkg;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Per-cycle commands broadcast to every cell of the row.
  typedef struct packed {
    logic cmp;        // latch live & (entry == id) into the match flag
    logic enq;        // tail cell takes id
    logic shift_all;  // every cell takes its right neighbor (dequeue)
    logic purge;      // cells at or past the first match take their right neighbor
  } fqp_ctrl_t;

endpackage

FILE: hdl/fifo_queue_with_purge.sv
`timescale 1ns / 1ps

// Ordered queue of 8-bit process handles, up to DEPTH entries, built as a row
// of cells with the head in cell 0. A command is taken when start is high and
// busy is low; every command gives exactly one result.
// busy is high in the cycle after the accepting edge. done rises at the
// edge where busy falls and stays high for that single cycle, and the result
// ports are valid only then. The receiver cannot stall: result ports must be
// sampled in the done cycle. The next command can be taken at the edge that
// ends the done cycle. The accepting edge latches a per-cell match flag
// (entry equals item_id and the cell is live); the busy cycle ripples the
// first-match flag along the row, shifts the entries and updates the count.
// Opcodes: enqueue appends at the tail or reports full; dequeue returns the
// head or reports empty; purge removes the first matching entry, closing
// the gap, or reports not found. Opcode 3 does nothing and reports ok.
// occupancy is the count after the command, cut to 5 bits.

module fifo_queue_with_purge
  import fqp_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OP_W-1:0]     opcode,
  input  logic [ID_W-1:0]     item_id,
  output logic                busy,
  output logic                done,
  output logic [ID_W-1:0]     result_item,
  output logic                result_valid,
  output logic [STATUS_W-1:0] status,
  output logic [OCC_W-1:0]    occupancy,
  output logic                is_empty
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]   count;
  logic [OP_W-1:0] op_q;
  logic [ID_W-1:0] id_q;

  fqp_ctrl_t       ctrl;
  logic [ID_W-1:0] cell_id;
  logic            full;
  logic            empty;
  logic            found;

  logic [ID_W-1:0] data  [DEPTH];
  logic [ID_W-1:0] nxt   [DEPTH];
  logic [ID_W-1:0] item  [DEPTH+1];
  logic [DEPTH:0]  hit;
  logic [DEPTH-1:0] live;
  logic [DEPTH-1:0] tail;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Compare against the incoming id at accept, write the held id afterwards.
  assign cell_id = busy ? id_q : item_id;

  assign hit[0]  = 1'b0;
  assign item[0] = '0;
  assign found   = hit[DEPTH];

  always_comb begin
    ctrl.cmp       = start & ~busy;
    ctrl.enq       = busy & (op_q == OP_ENQ) & ~full;
    ctrl.shift_all = busy & (op_q == OP_DEQ) & ~empty;
    ctrl.purge     = busy & (op_q == OP_PURGE) & found;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign live[i] = (CW'(i) < count);
    assign tail[i] = (CW'(i) == count);
    if (i == DEPTH - 1) begin : g_last
      assign nxt[i] = '0;
    end else begin : g_mid
      assign nxt[i] = data[i+1];
    end

    fqp_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .id       (cell_id),
      .live     (live[i]),
      .tail     (tail[i]),
      .nxt      (nxt[i]),
      .hit_in   (hit[i]),
      .item_in  (item[i]),
      .data     (data[i]),
      .hit_out  (hit[i+1]),
      .item_out (item[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        op_q <= opcode;
        id_q <= item_id;
      end else if (busy) begin
        busy         <= 1'b0;
        done         <= 1'b1;
        result_item  <= '0;
        result_valid <= 1'b0;
        status       <= ST_OK;
        occupancy    <= OCC_W'(count);
        is_empty     <= empty;
        unique case (op_q)
          OP_ENQ: begin
            if (full) begin
              status <= ST_FULL;
            end else begin
              count     <= count + 1'b1;
              occupancy <= OCC_W'(count + 1'b1);
              is_empty  <= 1'b0;
            end
          end
          OP_DEQ: begin
            if (empty) begin
              status <= ST_EMPTY;
            end else begin
              count        <= count - 1'b1;
              occupancy    <= OCC_W'(count - 1'b1);
              is_empty     <= (count == CW'(1));
              result_item  <= data[0];
              result_valid <= 1'b1;
            end
          end
          OP_PURGE: begin
            if (!found) begin
              status <= ST_NOTFOUND;
            end else begin
              count        <= count - 1'b1;
              occupancy    <= OCC_W'(count - 1'b1);
              is_empty     <= (count == CW'(1));
              result_item  <= item[DEPTH];
              result_valid <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: hdl/fqp_cell.sv
`timescale 1ns / 1ps

module fqp_cell
  import fqp_pkg::*;
(
  input  logic             clk,
  input  fqp_ctrl_t        ctrl,
  input  logic [ID_W-1:0]  id,
  input  logic             live,
  input  logic             tail,
  input  logic [ID_W-1:0]  nxt,
  input  logic             hit_in,
  input  logic [ID_W-1:0]  item_in,
  output logic [ID_W-1:0]  data,
  output logic             hit_out,
  output logic [ID_W-1:0]  item_out
);

  logic match;
  logic first;

  assign hit_out  = hit_in | match;
  assign first    = match & ~hit_in;
  assign item_out = item_in | (first ? data : '0);

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match <= live & (data == id);
    end
    if (ctrl.enq && tail) begin
      data <= id;
    end else if (ctrl.shift_all || (ctrl.purge && hit_out)) begin
      data <= nxt;
    end
  end

endmodule
